// ===== rtl/lpdx_pkg.sv =====
// Package for the length-prefix deframer with XOR decryption.
// Holds transaction structs, parser phase codes, key frame constants and the key table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpdx_pkg;

    typedef struct packed {
        logic       direction;
        logic [7:0] data_byte;
    } lpdx_in_t;

    typedef struct packed {
        logic        out_direction;
        logic [7:0]  payload_byte;
        logic        frame_last;
        logic        empty_frame;
        logic [15:0] frame_length;
        logic        key_loaded;
    } lpdx_out_t;

    // Per-direction parser status for the byte being processed
    typedef struct packed {
        logic        payload;
        logic        emit;
        logic        last;
        logic        empty;
        logic [15:0] length;
        logic [15:0] index;
    } lpdx_frame_info_t;

    // Request from the datapath to the key stream unit
    typedef struct packed {
        logic        c2s_step;
        logic        s2c_step;
        logic [15:0] index;
        logic [15:0] length;
        logic [7:0]  data_byte;
    } lpdx_key_req_t;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LEN_LO  = 4'b0010,
        PH_LEN_HI  = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } lpdx_phase_t;

    localparam logic [0:0]  DIR_C2S        = 1'b0;
    localparam logic [0:0]  DIR_S2C        = 1'b1;
    localparam logic [7:0]  KEY_MAGIC0     = 8'h07;
    localparam logic [7:0]  KEY_MAGIC1     = 8'h08;
    localparam logic [15:0] KEY_FRAME_LEN  = 16'd4;
    localparam logic [15:0] KEY_LOAD_INDEX = 16'd3;
    localparam logic [15:0] KEY_CAPTURE_N  = 16'd3;
    localparam int          KEY_ROM_DEPTH  = 512;
    localparam int          KEY_ROM_AW     = 9;

    localparam logic [7:0] KEY_TABLE [KEY_ROM_DEPTH] = '{
        8'h07, 8'h59, 8'h69, 8'h4A, 8'h94, 8'h11, 8'h94, 8'h85,
        8'h8C, 8'h88, 8'h05, 8'hCB, 8'hA0, 8'h9E, 8'hCD, 8'h58,
        8'h3A, 8'h36, 8'h5B, 8'h1A, 8'h6A, 8'h16, 8'hFE, 8'hBD,
        8'hDF, 8'h94, 8'h02, 8'hF8, 8'h21, 8'h96, 8'hC8, 8'hE9,
        8'h9E, 8'hF7, 8'hBF, 8'hBD, 8'hCF, 8'hCD, 8'hB2, 8'h7A,
        8'h00, 8'h9F, 8'h40, 8'h22, 8'hFC, 8'h11, 8'hF9, 8'h0C,
        8'h2E, 8'h12, 8'hFB, 8'hA7, 8'h74, 8'h0A, 8'h7D, 8'h78,
        8'h40, 8'h1E, 8'h2C, 8'hA0, 8'h2D, 8'h06, 8'hCB, 8'hA8,
        8'hB9, 8'h7E, 8'hEF, 8'hDE, 8'h49, 8'hEA, 8'h4E, 8'h13,
        8'h16, 8'h16, 8'h80, 8'hF4, 8'h3D, 8'hC2, 8'h9A, 8'hD4,
        8'h86, 8'hD7, 8'h94, 8'h24, 8'h17, 8'hF4, 8'hD6, 8'h65,
        8'hBD, 8'h3F, 8'hDB, 8'hE4, 8'hE1, 8'h0F, 8'h50, 8'hF6,
        8'hEC, 8'h7A, 8'h9A, 8'h0C, 8'h27, 8'h3D, 8'h24, 8'h66,
        8'hD3, 8'h22, 8'h68, 8'h9C, 8'h9A, 8'h52, 8'h0B, 8'hE0,
        8'hF9, 8'hA5, 8'h0B, 8'h25, 8'hDA, 8'h80, 8'h49, 8'h0D,
        8'hFD, 8'h3E, 8'h77, 8'hD1, 8'h56, 8'hA8, 8'hB7, 8'hF4,
        8'h0F, 8'h9B, 8'hE8, 8'h0F, 8'h52, 8'h47, 8'hF5, 8'h6F,
        8'h83, 8'h20, 8'h22, 8'hDB, 8'h0F, 8'h0B, 8'hB1, 8'h43,
        8'h85, 8'hC1, 8'hCB, 8'hA4, 8'h0B, 8'h02, 8'h19, 8'hDF,
        8'hF0, 8'h8B, 8'hEC, 8'hDB, 8'h6C, 8'h6D, 8'h66, 8'hAD,
        8'h45, 8'hBE, 8'h89, 8'h14, 8'h7E, 8'h2F, 8'h89, 8'h10,
        8'hB8, 8'h93, 8'h60, 8'hD8, 8'h60, 8'hDE, 8'hF6, 8'hFE,
        8'h6E, 8'h9B, 8'hCA, 8'h06, 8'hC1, 8'h75, 8'h95, 8'h33,
        8'hCF, 8'hC0, 8'hB2, 8'hE0, 8'hCC, 8'hA5, 8'hCE, 8'h12,
        8'hF6, 8'hE5, 8'hB5, 8'hB4, 8'h26, 8'hC5, 8'hB2, 8'h18,
        8'h4F, 8'h2A, 8'h5D, 8'h26, 8'h1B, 8'h65, 8'h4D, 8'hF5,
        8'h45, 8'hC9, 8'h84, 8'h14, 8'hDC, 8'h7C, 8'h12, 8'h4B,
        8'h18, 8'h9C, 8'hC7, 8'h24, 8'hE7, 8'h3C, 8'h64, 8'hFF,
        8'hD6, 8'h3A, 8'h2C, 8'hEE, 8'h8C, 8'h81, 8'h49, 8'h39,
        8'h6C, 8'hB7, 8'hDC, 8'hBD, 8'h94, 8'hE2, 8'h32, 8'hF7,
        8'hDD, 8'h0A, 8'hFC, 8'h02, 8'h01, 8'h64, 8'hEC, 8'h4C,
        8'h94, 8'h0A, 8'hB1, 8'h56, 8'hF5, 8'hC9, 8'hA9, 8'h34,
        8'hDE, 8'h0F, 8'h38, 8'h27, 8'hBC, 8'h81, 8'h30, 8'h0F,
        8'h7B, 8'h38, 8'h25, 8'hFE, 8'hE8, 8'h3E, 8'h29, 8'hBA,
        8'h55, 8'h43, 8'hBF, 8'h6B, 8'h9F, 8'h1F, 8'h8A, 8'h49,
        8'h52, 8'h18, 8'h7F, 8'h8A, 8'hF8, 8'h88, 8'h24, 8'h5C,
        8'h4F, 8'hE1, 8'hA8, 8'h30, 8'h87, 8'h8E, 8'h50, 8'h1F,
        8'h2F, 8'hD1, 8'h0C, 8'hB4, 8'hFD, 8'h0A, 8'hBC, 8'hDC,
        8'h12, 8'h85, 8'hE2, 8'h52, 8'hEE, 8'h4A, 8'h58, 8'h38,
        8'hAB, 8'hFF, 8'hC6, 8'h3D, 8'hB9, 8'h60, 8'h64, 8'h0A,
        8'hB4, 8'h50, 8'hD5, 8'h40, 8'h89, 8'h17, 8'h9A, 8'hD5,
        8'h85, 8'hCF, 8'hEC, 8'h0D, 8'h7E, 8'h81, 8'h7F, 8'hE3,
        8'hC3, 8'h04, 8'h01, 8'h22, 8'hEC, 8'h27, 8'hCC, 8'hFA,
        8'h3E, 8'h21, 8'hA6, 8'h54, 8'hC8, 8'hDE, 8'h00, 8'hB6,
        8'hDF, 8'h27, 8'h9F, 8'hF6, 8'h25, 8'h34, 8'h07, 8'h85,
        8'hBF, 8'hA7, 8'hA5, 8'hA5, 8'hE0, 8'h83, 8'h0C, 8'h3D,
        8'h5D, 8'h20, 8'h40, 8'hAF, 8'h60, 8'hA3, 8'h64, 8'h56,
        8'hF3, 8'h05, 8'hC4, 8'h1C, 8'h7D, 8'h37, 8'h98, 8'hC3,
        8'hE8, 8'h5A, 8'h6E, 8'h58, 8'h85, 8'hA4, 8'h9A, 8'h6B,
        8'h6A, 8'hF4, 8'hA3, 8'h7B, 8'h61, 8'h9B, 8'h09, 8'h40,
        8'h1E, 8'h60, 8'h4B, 8'h32, 8'hD9, 8'h51, 8'hA4, 8'hFE,
        8'hF9, 8'h5D, 8'h4E, 8'h4A, 8'hFB, 8'h4A, 8'hD4, 8'h7C,
        8'h33, 8'h02, 8'h33, 8'hD5, 8'h9D, 8'hCE, 8'h5B, 8'hAA,
        8'h5A, 8'h7C, 8'hD8, 8'hF8, 8'h05, 8'hFA, 8'h1F, 8'h2B,
        8'h8C, 8'h72, 8'h57, 8'h50, 8'hAE, 8'h6C, 8'h19, 8'h89,
        8'hCA, 8'h01, 8'hFC, 8'hFC, 8'h29, 8'h9B, 8'h61, 8'h12,
        8'h68, 8'h63, 8'h65, 8'h46, 8'h26, 8'hC4, 8'h5B, 8'h50,
        8'hAA, 8'h2B, 8'hBE, 8'hEF, 8'h9A, 8'h79, 8'h02, 8'h23,
        8'h75, 8'h2C, 8'h20, 8'h13, 8'hFD, 8'hD9, 8'h5A, 8'h76,
        8'h23, 8'hF1, 8'h0B, 8'hB5, 8'hB8, 8'h59, 8'hF9, 8'h9F,
        8'h7A, 8'hE6, 8'h06, 8'hE9, 8'hA5, 8'h3A, 8'hB4, 8'h50,
        8'hBF, 8'h16, 8'h58, 8'h98, 8'hB3, 8'h9A, 8'h6E, 8'h36,
        8'hEE, 8'h8D, 8'hEB, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

`default_nettype wire

// ===== rtl/lpdx_parser.sv =====
// Frame header parser for one direction of the stream.
// Tracks phase, frame length and payload count; depends on lpdx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpdx_parser
    import lpdx_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    output lpdx_frame_info_t      info
);

    lpdx_phase_t phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] taken_reg, taken_next;
    logic [16:0] taken_inc;

    assign taken_inc = {1'b0, taken_reg} + 17'd1;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        info       = '0;
        info.index = taken_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                len_next   = {8'h00, data_byte};
                taken_next = 16'd0;
                phase_next = (data_byte != 8'h00) ? PH_PAYLOAD : PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = {8'h00, data_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next   = {data_byte, len_reg[7:0]};
                taken_next = 16'd0;
                if (len_next == 16'd0)
                begin
                    // zero-length frame: one empty result
                    phase_next = PH_HEADER;
                    info.emit  = 1'b1;
                    info.last  = 1'b1;
                    info.empty = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                info.payload = 1'b1;
                info.emit    = 1'b1;
                info.length  = len_reg;
                info.last    = (taken_inc >= {1'b0, len_reg});
                taken_next   = taken_inc[15:0];
                if (info.last)
                begin
                    phase_next = PH_HEADER;
                end
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            len_reg   <= 16'd0;
            taken_reg <= 16'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lpdx_keystream.sv =====
// Key stream unit: key frame capture, decrypt enable, key position and key ROM.
// Depends on lpdx_pkg for the key table and key frame constants.
`timescale 1ns / 1ps
`default_nettype none

module lpdx_keystream
    import lpdx_pkg::*;
#(
    parameter int KEY_TABLE_LENGTH = 499
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lpdx_key_req_t req,
    output logic [7:0]         key_mask,
    output logic               key_loaded
);

    localparam int POS_W = (KEY_TABLE_LENGTH > 1) ? $clog2(KEY_TABLE_LENGTH) : 1;
    localparam logic [POS_W:0]   TAB_LEN  = (POS_W + 1)'(KEY_TABLE_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(KEY_TABLE_LENGTH - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             decrypt_on_reg, decrypt_on_next;
    logic [23:0]      cap_reg, cap_next;
    logic [7:0]       rom_reg;
    logic [KEY_ROM_AW-1:0] rom_addr;

    logic [POS_W-1:0] hi_mod [256];
    logic [POS_W-1:0] lo_mod [256];
    logic [POS_W:0]   mod_sum;
    logic [POS_W-1:0] load_pos;
    logic [POS_W-1:0] inc_pos;
    logic             load_hit;

    // Residue tables: (hi * 256) mod N and lo mod N, fixed at elaboration
    for (genvar g = 0; g < 256; g++)
    begin : g_mod_tab
        localparam int HI_V = (g * 256) % KEY_TABLE_LENGTH;
        localparam int LO_V = g % KEY_TABLE_LENGTH;
        assign hi_mod[g] = POS_W'(HI_V);
        assign lo_mod[g] = POS_W'(LO_V);
    end

    assign mod_sum  = {1'b0, hi_mod[req.data_byte]} + {1'b0, lo_mod[cap_reg[23:16]]};
    assign load_pos = (mod_sum >= TAB_LEN) ? POS_W'(mod_sum - TAB_LEN) : mod_sum[POS_W-1:0];
    assign inc_pos  = (pos_reg == POS_LAST) ? '0 : POS_W'({1'b0, pos_reg} + 1'b1);

    assign load_hit = req.s2c_step && (req.index == KEY_LOAD_INDEX)
                   && (req.length == KEY_FRAME_LEN)
                   && (cap_reg[7:0] == KEY_MAGIC0) && (cap_reg[15:8] == KEY_MAGIC1);

    always_comb
    begin
        cap_next        = cap_reg;
        pos_next        = pos_reg;
        decrypt_on_next = decrypt_on_reg;
        if (req.s2c_step && (req.index < KEY_CAPTURE_N))
        begin
            unique case (req.index[1:0])
                2'd0:    cap_next[7:0]   = req.data_byte;
                2'd1:    cap_next[15:8]  = req.data_byte;
                default: cap_next[23:16] = req.data_byte;
            endcase
        end
        if (load_hit)
        begin
            decrypt_on_next = 1'b1;
            pos_next        = load_pos;
        end
        else if (req.c2s_step && decrypt_on_reg)
        begin
            pos_next = inc_pos;
        end
    end

    assign rom_addr   = KEY_ROM_AW'(pos_next);
    assign key_mask   = decrypt_on_reg ? rom_reg : 8'h00;
    assign key_loaded = load_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            decrypt_on_reg <= 1'b0;
            cap_reg        <= 24'd0;
        end
        else
        begin
            pos_reg        <= pos_next;
            decrypt_on_reg <= decrypt_on_next;
            cap_reg        <= cap_next;
        end
    end

    // Key ROM read follows the next position so rom_reg tracks pos_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg <= KEY_TABLE[0];
        end
        else
        begin
            rom_reg <= KEY_TABLE[rom_addr];
        end
    end

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < TAB_LEN)
        else $error("key position out of table range");

    a_load_enables : assert property (@(posedge clk) disable iff (!rst_n)
        load_hit |=> decrypt_on_reg)
        else $error("key frame did not enable decryption");

    a_enable_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        decrypt_on_reg |=> decrypt_on_reg)
        else $error("decryption turned off");

endmodule

`default_nettype wire

// ===== rtl/length_prefix_deframer_xor_decrypt.sv =====
// Top level of the two-direction length-prefix deframer with XOR decryption.
// Instantiates lpdx_parser (one per direction) and lpdx_keystream; uses lpdx_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready/in_item): one raw byte per transaction,
//   tagged with its direction (0 client to server, 1 server to client).
//   Output channel (out_valid/out_ready/out_item): one transaction per payload
//   byte, or one empty-frame transaction for a zero-length frame. Header bytes
//   produce no output transaction.
//   Timing: an accepted byte is held in the input register and parsed there;
//   its result is loaded into the output register when the byte advances,
//   which a full output register that is not being drained holds back.
//   Throughput: one byte per cycle while the output register is free or draining.
//   The per-byte parse and the key position update are registered together, so
//   back-to-back bytes of either direction follow without gaps.
//   Key frames: a 4-byte server-to-client frame starting 07 08 turns
//   decryption on and loads the key position; the next byte of either
//   direction already uses the new state.
//   Reset: rst_n clears both parsers to await a header, turns decryption off
//   and sets the key position to zero; no transactions are pending.
//   Stall: while out_ready is low the result holds in the output register and
//   one more byte is taken into the input register; then in_ready drops
//   until the result is taken.
module length_prefix_deframer_xor_decrypt
    import lpdx_pkg::*;
#(
    parameter int KEY_TABLE_LENGTH = 499
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire lpdx_in_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output lpdx_out_t      out_item
);

    logic             in_valid_reg;
    lpdx_in_t         in_item_reg;
    logic             out_valid_reg, out_valid_next;
    lpdx_out_t        out_item_reg, out_item_next;

    logic             advance;
    logic             step_c2s, step_s2c;
    lpdx_frame_info_t info_c2s, info_s2c, info_sel;
    lpdx_key_req_t    key_req;
    logic [7:0]       key_mask;
    logic             key_loaded;

    // Process the held byte whenever the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign step_c2s = advance && (in_item_reg.direction == DIR_C2S);
    assign step_s2c = advance && (in_item_reg.direction == DIR_S2C);

    lpdx_parser u_parser_c2s (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step_c2s),
        .data_byte (in_item_reg.data_byte),
        .info      (info_c2s)
    );

    lpdx_parser u_parser_s2c (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step_s2c),
        .data_byte (in_item_reg.data_byte),
        .info      (info_s2c)
    );

    assign info_sel = (in_item_reg.direction == DIR_S2C) ? info_s2c : info_c2s;

    always_comb
    begin
        key_req           = '0;
        key_req.c2s_step  = step_c2s && info_c2s.payload;
        key_req.s2c_step  = step_s2c && info_s2c.payload;
        key_req.index     = info_sel.index;
        key_req.length    = info_sel.length;
        key_req.data_byte = in_item_reg.data_byte;
    end

    lpdx_keystream #(
        .KEY_TABLE_LENGTH (KEY_TABLE_LENGTH)
    ) u_keystream (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (key_req),
        .key_mask   (key_mask),
        .key_loaded (key_loaded)
    );

    // Build the result: XOR only client-to-server payload bytes
    always_comb
    begin
        out_item_next               = '0;
        out_item_next.out_direction = in_item_reg.direction;
        out_item_next.frame_last    = info_sel.last;
        out_item_next.empty_frame   = info_sel.empty;
        out_item_next.frame_length  = info_sel.length;
        out_item_next.key_loaded    = key_loaded;
        if (info_sel.payload)
        begin
            out_item_next.payload_byte = (in_item_reg.direction == DIR_C2S)
                                       ? (in_item_reg.data_byte ^ key_mask)
                                       : in_item_reg.data_byte;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && info_sel.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Input register: take a new transaction whenever ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_item;
        end
    end

    // Output register: load on an emitting byte, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && info_sel.emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_key_loaded_frame : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.key_loaded) |->
            (out_item_reg.frame_last && (out_item_reg.out_direction == DIR_S2C)
             && (out_item_reg.frame_length == KEY_FRAME_LEN)))
        else $error("key load flagged outside a server key frame end");

    a_empty_frame : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.empty_frame) |->
            (out_item_reg.frame_last && (out_item_reg.frame_length == 16'd0)
             && (out_item_reg.payload_byte == 8'h00) && !out_item_reg.key_loaded))
        else $error("malformed empty-frame result");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked output");

endmodule

`default_nettype wire
